FILE: rtl/pnr_pkg.sv
package pnr_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [31:0] arrival;
        logic [31:0] travel;
        logic [31:0] waiting;
        logic [31:0] cost;
        logic [15:0] transfer;
    } obj_t;

    // one command from the load side to the ranking engine
    typedef struct packed {
        obj_t             obj;
        logic             store;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             ovf;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BUILD,
        BK_PEEL,
        BK_OUT
    } back_state_t;

    // a dominates b: nowhere greater, somewhere smaller
    function automatic logic beats(obj_t a, obj_t b);
        logic worse;
        logic better;
        worse  = (a.arrival > b.arrival) || (a.travel > b.travel) ||
                 (a.waiting > b.waiting) || (a.cost > b.cost) ||
                 (a.transfer > b.transfer);
        better = (a.arrival < b.arrival) || (a.travel < b.travel) ||
                 (a.waiting < b.waiting) || (a.cost < b.cost) ||
                 (a.transfer < b.transfer);
        return !worse && better;
    endfunction

endpackage

FILE: rtl/pnr_front.sv
module pnr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [31:0]         arrival_time,
    input  logic [31:0]         travel_time,
    input  logic [31:0]         waiting_time,
    input  logic [31:0]         route_cost,
    input  logic [15:0]         transfer_count,
    input  logic                last_item,
    input  logic                q_full,
    output logic                push,
    output pnr_pkg::cmd_t       push_cmd
);

    logic [pnr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      room;

    assign busy = q_full;
    assign push = start && !busy;
    assign room = (cnt_reg < pnr_pkg::CNT_W'(pnr_pkg::MAX_ITEMS));

    // classify the item: stored or dropped, and close the set on last
    always_comb
    begin
        push_cmd.obj.arrival  = arrival_time;
        push_cmd.obj.travel   = travel_time;
        push_cmd.obj.waiting  = waiting_time;
        push_cmd.obj.cost     = route_cost;
        push_cmd.obj.transfer = transfer_count;
        push_cmd.store        = room;
        push_cmd.idx          = cnt_reg[pnr_pkg::IDX_W-1:0];
        push_cmd.count        = room ? cnt_reg + 1'b1 : cnt_reg;
        push_cmd.last         = last_item;
        push_cmd.ovf          = ovf_reg || !room;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (push)
        begin
            if (last_item)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = push_cmd.count;
                ovf_next = push_cmd.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

FILE: rtl/pnr_queue.sv
module pnr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pnr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output pnr_pkg::cmd_t head
);

    pnr_pkg::cmd_t                 slot_reg [pnr_pkg::Q_DEPTH];
    logic [pnr_pkg::Q_PTR_W-1:0]   wr_reg, wr_next;
    logic [pnr_pkg::Q_PTR_W-1:0]   rd_reg, rd_next;
    logic [pnr_pkg::Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          do_pop;

    function automatic logic [pnr_pkg::Q_CNT_W-1:0] Q_ext(logic b);
        return {{(pnr_pkg::Q_CNT_W-1){1'b0}}, b};
    endfunction

    assign full      = (cnt_reg == pnr_pkg::Q_CNT_W'(pnr_pkg::Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];
    assign do_pop    = pop && not_empty;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_ext(push) - Q_ext(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/pnr_back.sv
module pnr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  pnr_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        result_valid,
    output logic [pnr_pkg::IDX_W-1:0]   item_index,
    output logic [pnr_pkg::IDX_W-1:0]   front_rank,
    output logic                        overflowed,
    output logic                        last_result
);

    localparam int N = pnr_pkg::MAX_ITEMS;
    localparam int W = pnr_pkg::IDX_W;

    // stores
    pnr_pkg::obj_t obj_mem  [N];
    logic [N-1:0]  dom_mem  [N];
    logic [W-1:0]  rank_mem [N];
    pnr_pkg::obj_t rd_a_reg, rd_b_reg;
    logic [N-1:0]  dom_rd_reg;
    logic [W-1:0]  rank_rd_reg;

    pnr_pkg::back_state_t state_reg, state_next;
    logic [pnr_pkg::CNT_W-1:0] n_reg, n_next;
    logic                      ovf_reg, ovf_next;
    logic [W-1:0]  bi_reg, bi_next, bj_reg, bj_next;
    logic          done_reg, done_next;
    logic          s1_v_reg, s1_v_next, s1_last_reg, s1_last_next;
    logic [W-1:0]  s1_i_reg, s1_i_next, s1_j_reg, s1_j_next;
    logic [N-1:0]  col_reg, col_next;
    logic [N-1:0]  unr_reg, unr_next, snap_reg, snap_next;
    logic [W-1:0]  level_reg, level_next;
    logic [N-1:0]  mask;
    logic [W-1:0]  n_m1;
    logic          issue, dom_bit, drained;
    logic          obj_we, dom_we, rank_we;
    logic          out_v_next, out_last_next;

    assign n_m1    = W'(n_reg - 1'b1);
    assign issue   = (state_reg != pnr_pkg::BK_IDLE) && !done_reg;
    assign drained = done_reg && !s1_v_reg;
    assign cmd_pop = (state_reg == pnr_pkg::BK_IDLE) && cmd_valid;
    assign obj_we  = cmd_pop && cmd.store;
    assign dom_bit = pnr_pkg::beats(rd_a_reg, rd_b_reg);

    // ones below the set size
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            mask[k] = (pnr_pkg::CNT_W'(k) < n_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pnr_pkg::BK_IDLE:
            begin
                if (cmd_pop && cmd.last)
                begin
                    state_next = pnr_pkg::BK_BUILD;
                end
            end
            pnr_pkg::BK_BUILD:
            begin
                if (drained)
                begin
                    state_next = pnr_pkg::BK_PEEL;
                end
            end
            pnr_pkg::BK_PEEL:
            begin
                if (drained && (unr_reg == '0))
                begin
                    state_next = pnr_pkg::BK_OUT;
                end
            end
            pnr_pkg::BK_OUT:
            begin
                if (drained)
                begin
                    state_next = pnr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pnr_pkg::BK_IDLE;
            end
        endcase
    end

    // issue counters, compare stage and front peeling
    always_comb
    begin
        n_next        = n_reg;
        ovf_next      = ovf_reg;
        bi_next       = bi_reg;
        bj_next       = bj_reg;
        done_next     = done_reg;
        col_next      = col_reg;
        unr_next      = unr_reg;
        snap_next     = snap_reg;
        level_next    = level_reg;
        dom_we        = 1'b0;
        rank_we       = 1'b0;
        out_v_next    = 1'b0;
        out_last_next = 1'b0;
        s1_v_next     = issue;
        s1_i_next     = bi_reg;
        s1_j_next     = bj_reg;
        s1_last_next  = (bi_reg == n_m1);

        // walk pair or entry addresses
        if (issue)
        begin
            if (state_reg == pnr_pkg::BK_BUILD)
            begin
                if (bi_reg == n_m1)
                begin
                    bi_next = '0;
                    if (bj_reg == n_m1)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        bj_next = bj_reg + 1'b1;
                    end
                end
                else
                begin
                    bi_next = bi_reg + 1'b1;
                end
            end
            else
            begin
                if (bj_reg == n_m1)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    bj_next = bj_reg + 1'b1;
                end
            end
        end

        // result of the registered read
        if (s1_v_reg)
        begin
            case (state_reg)
                pnr_pkg::BK_BUILD:
                begin
                    col_next[s1_i_reg] = dom_bit;
                    if (s1_last_reg)
                    begin
                        dom_we   = 1'b1;
                        col_next = '0;
                    end
                end
                pnr_pkg::BK_PEEL:
                begin
                    if (snap_reg[s1_j_reg] && ((dom_rd_reg & snap_reg) == '0))
                    begin
                        rank_we            = 1'b1;
                        unr_next[s1_j_reg] = 1'b0;
                    end
                end
                pnr_pkg::BK_OUT:
                begin
                    out_v_next    = 1'b1;
                    out_last_next = (s1_j_reg == n_m1);
                end
                default:
                begin
                end
            endcase
        end

        // phase changes
        case (state_reg)
            pnr_pkg::BK_IDLE:
            begin
                if (cmd_pop && cmd.last)
                begin
                    n_next    = cmd.count;
                    ovf_next  = cmd.ovf;
                    bi_next   = '0;
                    bj_next   = '0;
                    done_next = 1'b0;
                    col_next  = '0;
                end
            end
            pnr_pkg::BK_BUILD:
            begin
                if (drained)
                begin
                    bj_next    = '0;
                    done_next  = 1'b0;
                    unr_next   = mask;
                    snap_next  = mask;
                    level_next = '0;
                end
            end
            pnr_pkg::BK_PEEL:
            begin
                if (drained)
                begin
                    bj_next   = '0;
                    done_next = 1'b0;
                    if (unr_reg != '0)
                    begin
                        level_next = level_reg + 1'b1;
                        snap_next  = unr_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pnr_pkg::BK_IDLE;
            done_reg     <= 1'b1;
            s1_v_reg     <= 1'b0;
            result_valid <= 1'b0;
            n_reg        <= '0;
            ovf_reg      <= 1'b0;
            bi_reg       <= '0;
            bj_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            s1_v_reg     <= s1_v_next;
            result_valid <= out_v_next;
            n_reg        <= n_next;
            ovf_reg      <= ovf_next;
            bi_reg       <= bi_next;
            bj_reg       <= bj_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s1_i_reg    <= s1_i_next;
        s1_j_reg    <= s1_j_next;
        s1_last_reg <= s1_last_next;
        col_reg     <= col_next;
        unr_reg     <= unr_next;
        snap_reg    <= snap_next;
        level_reg   <= level_next;
        item_index  <= s1_j_reg;
        front_rank  <= rank_rd_reg;
        overflowed  <= ovf_reg;
        last_result <= out_last_next;
    end

    // objective store, two read ports
    always_ff @(posedge clk)
    begin
        if (obj_we)
        begin
            obj_mem[cmd.idx] <= cmd.obj;
        end
        rd_a_reg <= obj_mem[bi_reg];
        rd_b_reg <= obj_mem[bj_reg];
    end

    // dominator columns: bit i of entry j set when i dominates j
    always_ff @(posedge clk)
    begin
        if (dom_we)
        begin
            dom_mem[s1_j_reg] <= col_next | col_reg | ({{(N-1){1'b0}}, dom_bit} << s1_i_reg);
        end
        dom_rd_reg <= dom_mem[bj_reg];
    end

    // rank store
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[s1_j_reg] <= level_reg;
        end
        rank_rd_reg <= rank_mem[bj_reg];
    end

endmodule

FILE: rtl/pareto_nondominated_rank.sv
// loading: one item per cycle while the 4-entry command queue has room (busy = queue full)
// a set closes on last_item: the pairwise dominance pass compares every ordered pair, front peeling
// scans all n entries once per front, then n results leave on consecutive cycles, one per strobe
// the closing item is taken only by an idle engine; dominance is tested by a single comparator
// rst_n clears counters, queue and sequencer; stores hold no reset; the receiver cannot stall
module pareto_nondominated_rank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] arrival_time,
    input  logic [31:0] travel_time,
    input  logic [31:0] waiting_time,
    input  logic [31:0] route_cost,
    input  logic [15:0] transfer_count,
    input  logic        last_item,
    output logic        result_valid,
    output logic [5:0]  item_index,
    output logic [5:0]  front_rank,
    output logic        overflowed,
    output logic        last_result
);

    pnr_pkg::cmd_t push_cmd, head;
    logic          push, q_full, pop, not_empty;

    // load side: count and classify each item
    pnr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .arrival_time   (arrival_time),
        .travel_time    (travel_time),
        .waiting_time   (waiting_time),
        .route_cost     (route_cost),
        .transfer_count (transfer_count),
        .last_item      (last_item),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // decoupling queue
    pnr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // ranking engine
    pnr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (not_empty),
        .cmd          (head),
        .cmd_pop      (pop),
        .result_valid (result_valid),
        .item_index   (item_index),
        .front_rank   (front_rank),
        .overflowed   (overflowed),
        .last_result  (last_result)
    );

endmodule

FILE: rtl/pnr_checker.sv
module pnr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic [5:0] item_index,
    input logic       overflowed,
    input logic       last_result
);

    // a set ends with a gap before any next set
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_result |=> !result_valid)
        else $error("result right after last result");

    // results of a set run back to back in load order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=>
            result_valid && (item_index == 6'($past(item_index) + 6'd1)))
        else $error("result run broken or out of order");

    // a set starts at item zero
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid) |-> item_index == 6'd0)
        else $error("set does not start at item zero");

    // overflow flag constant over one set
    a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> $stable(overflowed))
        else $error("overflow flag changed within a set");

endmodule

bind pareto_nondominated_rank pnr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .item_index   (item_index),
    .overflowed   (overflowed),
    .last_result  (last_result)
);

FILE: tb/tb_pareto_nondominated_rank.sv
module tb_pareto_nondominated_rank;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 50;
    localparam int ITEM_TARGET = 220;

    typedef struct {
        pnr_pkg::obj_t obj;
        logic          last;
    } route_item_t;

    typedef struct {
        logic [5:0] idx;
        logic [5:0] rank;
        logic       ovf;
        logic       last;
    } rank_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] arrival_time;
    logic [31:0] travel_time;
    logic [31:0] waiting_time;
    logic [31:0] route_cost;
    logic [15:0] transfer_count;
    logic        last_item;
    logic        result_valid;
    logic [5:0]  item_index;
    logic [5:0]  front_rank;
    logic        overflowed;
    logic        last_result;

    route_item_t   pending_items[$];
    rank_result_t  expected_ranks[$];
    pnr_pkg::obj_t loaded_set[$];
    logic          set_dropped;
    int            error_count;
    int            idle_cycles;
    int            gap_left;

    pareto_nondominated_rank dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .arrival_time(arrival_time),
        .travel_time(travel_time),
        .waiting_time(waiting_time),
        .route_cost(route_cost),
        .transfer_count(transfer_count),
        .last_item(last_item),
        .result_valid(result_valid),
        .item_index(item_index),
        .front_rank(front_rank),
        .overflowed(overflowed),
        .last_result(last_result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // a beats b: no objective greater, at least one smaller
    function automatic bit route_beats(pnr_pkg::obj_t a, pnr_pkg::obj_t b);
        bit worse;
        bit better;
        worse  = a.arrival > b.arrival || a.travel > b.travel || a.waiting > b.waiting ||
                 a.cost > b.cost || a.transfer > b.transfer;
        better = a.arrival < b.arrival || a.travel < b.travel || a.waiting < b.waiting ||
                 a.cost < b.cost || a.transfer < b.transfer;
        return !worse && better;
    endfunction

    // peel fronts over the loaded set and queue one rank result per candidate
    function automatic void rank_loaded_set();
        int          n;
        int          level;
        int          pending_doms[64];
        bit [63:0]   beaten_by[64];
        bit [63:0]   front;
        bit [63:0]   next_front;
        logic [5:0]  ranks[64];
        rank_result_t res;
        n = loaded_set.size();
        front = '0;
        for (int i = 0; i < n; i++)
        begin
            beaten_by[i] = '0;
            pending_doms[i] = 0;
            for (int j = 0; j < n; j++)
            begin
                if (i != j && route_beats(loaded_set[i], loaded_set[j]))
                    beaten_by[i][j] = 1'b1;
                else if (i != j && route_beats(loaded_set[j], loaded_set[i]))
                    pending_doms[i]++;
            end
            if (pending_doms[i] == 0)
            begin
                ranks[i] = '0;
                front[i] = 1'b1;
            end
        end
        level = 0;
        while (front != '0)
        begin
            next_front = '0;
            for (int i = 0; i < n; i++)
            begin
                if (!front[i])
                    continue;
                for (int j = 0; j < n; j++)
                begin
                    if (!beaten_by[i][j])
                        continue;
                    if (pending_doms[j] != 0)
                        pending_doms[j]--;
                    if (pending_doms[j] == 0)
                    begin
                        ranks[j] = 6'(level + 1);
                        next_front[j] = 1'b1;
                    end
                end
            end
            level++;
            front = next_front;
        end
        for (int k = 0; k < n; k++)
        begin
            res.idx  = 6'(k);
            res.rank = ranks[k];
            res.ovf  = set_dropped;
            res.last = (k == n - 1);
            expected_ranks.insert(expected_ranks.size(), res);
        end
        loaded_set.delete();
        set_dropped = 1'b0;
    endfunction

    // load one accepted item into the predicted set
    function automatic void load_route(route_item_t it);
        if (loaded_set.size() < pnr_pkg::MAX_ITEMS)
            loaded_set.insert(loaded_set.size(), it.obj);
        else
            set_dropped = 1'b1;
        if (it.last)
            rank_loaded_set();
    endfunction

    // mostly short gaps, some long, many none
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    // objective vector: narrow values give dense dominance, wide ones toggle every bit, some all ones
    function automatic pnr_pkg::obj_t make_route();
        pnr_pkg::obj_t o;
        int            mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            o.arrival  = $urandom_range(0, 3);
            o.travel   = $urandom_range(0, 3);
            o.waiting  = $urandom_range(0, 3);
            o.cost     = $urandom_range(0, 3);
            o.transfer = 16'($urandom_range(0, 3));
        end
        else if (mode < 9)
        begin
            o.arrival  = $urandom;
            o.travel   = $urandom;
            o.waiting  = $urandom;
            o.cost     = $urandom;
            o.transfer = 16'($urandom);
        end
        else
        begin
            o.arrival  = '1;
            o.travel   = '1;
            o.waiting  = '1;
            o.cost     = '1;
            o.transfer = '1;
        end
        return o;
    endfunction

    function automatic void add_route(pnr_pkg::obj_t o, logic last);
        route_item_t it;
        it.obj  = o;
        it.last = last;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic pnr_pkg::obj_t fill_route(logic [31:0] v, logic [15:0] t);
        pnr_pkg::obj_t o;
        o.arrival  = v;
        o.travel   = v;
        o.waiting  = v;
        o.cost     = v;
        o.transfer = t;
        return o;
    endfunction

    function automatic void add_random_set(int size);
        for (int k = 0; k < size; k++)
            add_route(make_route(), k == size - 1);
    endfunction

    // driver: hold while busy, then next item after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        route_item_t it;
        if (!rst_n)
        begin
            start          <= 1'b0;
            arrival_time   <= '0;
            travel_time    <= '0;
            waiting_time   <= '0;
            route_cost     <= '0;
            transfer_count <= '0;
            last_item      <= 1'b0;
            gap_left        = 0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                it.obj.arrival  = arrival_time;
                it.obj.travel   = travel_time;
                it.obj.waiting  = waiting_time;
                it.obj.cost     = route_cost;
                it.obj.transfer = transfer_count;
                it.last         = last_item;
                load_route(it);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                arrival_time   <= it.obj.arrival;
                travel_time    <= it.obj.travel;
                waiting_time   <= it.obj.waiting;
                route_cost     <= it.obj.cost;
                transfer_count <= it.obj.transfer;
                last_item      <= it.last;
                start          <= 1'b1;
                gap_left        = pick_gap();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each strobed result with the oldest expected rank
    always @(posedge clk)
    begin
        rank_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_ranks.size() == 0)
            begin
                $error("unexpected result: item_index %0d front_rank %0d",
                       item_index, front_rank);
                error_count++;
            end
            else
            begin
                want = expected_ranks.pop_front();
                if (item_index !== want.idx)
                begin
                    $error("item_index expected %0d actual %0d", want.idx, item_index);
                    error_count++;
                end
                if (front_rank !== want.rank)
                begin
                    $error("front_rank expected %0d actual %0d", want.rank, front_rank);
                    error_count++;
                end
                if (overflowed !== want.ovf)
                begin
                    $error("overflowed expected %0b actual %0b", want.ovf, overflowed);
                    error_count++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result expected %0b actual %0b", want.last, last_result);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item accepted and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and end of run
    initial
    begin
        pnr_pkg::obj_t o;
        error_count = 0;
        idle_cycles = 0;
        set_dropped = 1'b0;
        rst_n = 1'b0;

        // single candidate set
        add_route(fill_route('0, '0), 1'b1);
        // extremes, equal pair, one-field improvements
        add_route(fill_route('1, '1), 1'b0);
        add_route(fill_route('0, '0), 1'b0);
        add_route(fill_route(32'd5, 16'd5), 1'b0);
        add_route(fill_route(32'd5, 16'd5), 1'b0);
        o = fill_route(32'd5, 16'd5);
        o.arrival = 32'd4;
        add_route(o, 1'b0);
        o = fill_route(32'd5, 16'd5);
        o.travel = 32'd4;
        add_route(o, 1'b0);
        o = fill_route(32'd5, 16'd5);
        o.waiting = 32'd4;
        add_route(o, 1'b0);
        o = fill_route(32'd5, 16'd5);
        o.cost = 32'd4;
        add_route(o, 1'b0);
        o = fill_route(32'd5, 16'd5);
        o.transfer = 16'd4;
        add_route(o, 1'b0);
        o = fill_route(32'd6, 16'd6);
        o.arrival = '1;
        add_route(o, 1'b1);
        // equal candidates alone
        add_route(fill_route(32'hA5A5_5A5A, 16'h5A5A), 1'b0);
        add_route(fill_route(32'hA5A5_5A5A, 16'h5A5A), 1'b1);
        // descending chain of eight fronts
        for (int k = 0; k < 8; k++)
            add_route(fill_route(32'(7 - k), 16'(7 - k)), k == 7);

        // random sets, mostly small, leaving room for the capacity sets below
        while (pending_items.size() + 2 * pnr_pkg::MAX_ITEMS + 6 < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                add_random_set($urandom_range(9, 20));
            else
                add_random_set($urandom_range(1, 8));
        end
        // full set, then overflow with the closing item dropped
        add_random_set(pnr_pkg::MAX_ITEMS);
        add_random_set(pnr_pkg::MAX_ITEMS + 3);
        add_random_set(3);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_items.size() > 0 || start || expected_ranks.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/pnr_pkg.sv
rtl/pnr_front.sv
rtl/pnr_queue.sv
rtl/pnr_back.sv
rtl/pareto_nondominated_rank.sv
rtl/pnr_checker.sv
tb/tb_pareto_nondominated_rank.sv
